FILE: sv/assert_macros.svh
// Assertion macros for the checker file of the tray positioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/stp_pkg.sv
// Shared types, constants and helper functions of the stepper tray positioner.
package stp_pkg;

  localparam int PERIOD_W    = 5;
  localparam int STEPS_W     = 8;
  localparam int TRAY_W      = 2;
  localparam int PHASE_W     = 2;
  localparam int PATTERN_W   = 6;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  // Signed width for the period and ramp arithmetic (step counts up to 255)
  localparam int CALC_W      = 10;

  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [STEPS_W-1:0]   steps_t;
  typedef logic [TRAY_W-1:0]    tray_t;
  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [PATTERN_W-1:0] pattern_t;
  typedef logic signed [CALC_W-1:0] calc_t;

  // Item kinds
  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Tray distance codes, target minus current modulo four
  localparam tray_t DIST_SAME = 2'd0;
  localparam tray_t DIST_FWD  = 2'd1;
  localparam tray_t DIST_HALF = 2'd2;
  localparam tray_t DIST_REV  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_STEP = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_STEP    = 8'd3;

  // Reset values
  localparam period_t  SLOW_PERIOD_RST  = 5'd10;
  localparam period_t  FAST_PERIOD_RST  = 5'd6;
  localparam steps_t   QUARTER_STEP_RST = 8'd50;
  localparam steps_t   HALF_STEP_RST    = 8'd100;
  localparam pattern_t PATTERN_RST      = 6'h35;

  // Hold time limits
  localparam period_t PERIOD_MIN = 5'd1;
  localparam period_t PERIOD_MAX = 5'd31;

  // Coil pattern table; reverse moves read it backwards
  function automatic pattern_t coil_lookup(input phase_t ph, input logic rev);
    phase_t idx;
    pattern_t pat;
    idx = rev ? ~ph : ph;
    unique case (idx)
      2'd0:    pat = 6'h35;
      2'd1:    pat = 6'h36;
      2'd2:    pat = 6'h2E;
      default: pat = 6'h2D;
    endcase
    return pat;
  endfunction

  // Saturate a hold time to 1..31
  function automatic period_t clamp_period(input calc_t p);
    period_t r;
    if (p < calc_t'(PERIOD_MIN)) begin
      r = PERIOD_MIN;
    end else if (p > calc_t'(PERIOD_MAX)) begin
      r = PERIOD_MAX;
    end else begin
      r = p[PERIOD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/stepper_tray_positioner_core.sv
// Top level of the stepper tray positioner: move sequencing, step ramp and result register.
// Usage
//   Input channel (in_valid/in_ready): each transaction is either a move command
//   (kind = 0, target_tray) or a one millisecond tick (kind = 1).
//   Output channel (out_valid/out_ready): exactly one result per input transaction,
//   in order: coil_pattern, moving, move_done, rejected.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes slow_period,
//   fast_period, quarter_turn_steps and half_turn_steps; cfg_ready is always high.
//   Writes with an index past the last register are taken and ignored.
// Timing
//   An item is handled in the cycle it is accepted and its result is registered in the output
//   register at the end of that cycle; throughput one item per cycle while out_ready stays high.
//   The state update is a single pass of adders and compares ahead of the result register.
// Reset
//   rst is synchronous: the tray sits at position 0, phase 0, drive pattern 0x35, idle,
//   registers take their reset values and the output register is empty.
// Stall
//   While a result waits and out_ready is low, in_ready drops; a new item is taken in the
//   same cycle that the waiting result leaves, so a steady consumer sees no bubbles.
module stepper_tray_positioner_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [stp_pkg::TRAY_W-1:0]          target_tray,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stp_pkg::PATTERN_W-1:0]       coil_pattern,
  output logic                                moving,
  output logic                                move_done,
  output logic                                rejected,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  stp_pkg::period_t slow_period;
  stp_pkg::period_t fast_period;
  stp_pkg::steps_t  quarter_turn_steps;
  stp_pkg::steps_t  half_turn_steps;

  // Motion state
  stp_pkg::tray_t    tray_position, tray_position_next;
  stp_pkg::phase_t   phase_index, phase_index_next;
  stp_pkg::period_t  step_period, step_period_next;
  stp_pkg::period_t  tick_count, tick_count_next;
  stp_pkg::steps_t   step_index, step_index_next;
  stp_pkg::steps_t   step_total, step_total_next;
  logic              reverse_dir, reverse_dir_next;
  logic              busy, busy_next;
  stp_pkg::pattern_t drive_pattern, drive_pattern_next;
  logic              done_next, rej_next;

  // Intermediate values
  stp_pkg::tray_t   tray_delta;
  stp_pkg::steps_t  move_total;
  logic             move_rev;
  stp_pkg::period_t tick_inc;
  stp_pkg::steps_t  index_inc;
  stp_pkg::calc_t   ramp;
  stp_pkg::calc_t   remaining;
  stp_pkg::calc_t   period_dn;
  stp_pkg::calc_t   period_up;

  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_period        <= stp_pkg::SLOW_PERIOD_RST;
      fast_period        <= stp_pkg::FAST_PERIOD_RST;
      quarter_turn_steps <= stp_pkg::QUARTER_STEP_RST;
      half_turn_steps    <= stp_pkg::HALF_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stp_pkg::REG_SLOW_PERIOD:  slow_period        <= cfg_data[stp_pkg::PERIOD_W-1:0];
        stp_pkg::REG_FAST_PERIOD:  fast_period        <= cfg_data[stp_pkg::PERIOD_W-1:0];
        stp_pkg::REG_QUARTER_STEP: quarter_turn_steps <= cfg_data;
        stp_pkg::REG_HALF_STEP:    half_turn_steps    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move decode: step count and direction from the tray distance
  assign tray_delta = target_tray - tray_position;

  always_comb begin
    move_total = '0;
    move_rev   = 1'b0;
    unique case (tray_delta)
      stp_pkg::DIST_FWD:  move_total = quarter_turn_steps;
      stp_pkg::DIST_REV: begin
        move_total = quarter_turn_steps;
        move_rev   = 1'b1;
      end
      stp_pkg::DIST_HALF: move_total = half_turn_steps;
      default:            move_total = '0;
    endcase
  end

  // Ramp arithmetic for the end of a step
  assign tick_inc  = tick_count + stp_pkg::period_t'(1);
  assign index_inc = step_index + stp_pkg::steps_t'(1);
  assign ramp      = $signed({5'd0, slow_period}) - $signed({5'd0, fast_period});
  assign remaining = $signed({2'd0, step_total}) - $signed({2'd0, step_index});

  // Speed up over the first steps, slow down over the last ones
  always_comb begin
    period_dn = $signed({5'd0, step_period});
    if ($signed({2'd0, step_index}) < ramp && step_period >= fast_period) begin
      period_dn = period_dn - stp_pkg::calc_t'(1);
    end
    period_up = period_dn;
    if (remaining <= ramp && period_dn <= $signed({5'd0, slow_period})) begin
      period_up = period_dn + stp_pkg::calc_t'(1);
    end
  end

  // Next state for one item
  always_comb begin
    tray_position_next = tray_position;
    phase_index_next   = phase_index;
    step_period_next   = step_period;
    tick_count_next    = tick_count;
    step_index_next    = step_index;
    step_total_next    = step_total;
    reverse_dir_next   = reverse_dir;
    busy_next          = busy;
    drive_pattern_next = drive_pattern;
    done_next          = 1'b0;
    rej_next           = 1'b0;

    if (kind == stp_pkg::KIND_MOVE) begin
      if (busy) begin
        rej_next = 1'b1;
      end else begin
        tray_position_next = target_tray;
        if (tray_delta == stp_pkg::DIST_SAME || move_total == '0) begin
          done_next = 1'b1;
        end else begin
          reverse_dir_next   = move_rev;
          step_total_next    = move_total;
          step_index_next    = '0;
          tick_count_next    = '0;
          step_period_next   = stp_pkg::clamp_period($signed({5'd0, slow_period}));
          busy_next          = 1'b1;
          drive_pattern_next = stp_pkg::coil_lookup(phase_index, move_rev);
          phase_index_next   = phase_index + stp_pkg::phase_t'(1);
        end
      end
    end else if (busy) begin
      tick_count_next = tick_inc;
      if (tick_inc >= step_period) begin
        step_period_next = stp_pkg::clamp_period(period_up);
        tick_count_next  = '0;
        step_index_next  = index_inc;
        if (index_inc >= step_total) begin
          busy_next = 1'b0;
          done_next = 1'b1;
        end else begin
          drive_pattern_next = stp_pkg::coil_lookup(phase_index, reverse_dir);
          phase_index_next   = phase_index + stp_pkg::phase_t'(1);
        end
      end
    end
  end

  // State registers, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      tray_position <= '0;
      phase_index   <= '0;
      step_period   <= stp_pkg::SLOW_PERIOD_RST;
      tick_count    <= '0;
      step_index    <= '0;
      step_total    <= '0;
      reverse_dir   <= 1'b0;
      busy          <= 1'b0;
      drive_pattern <= stp_pkg::PATTERN_RST;
    end else if (in_fire) begin
      tray_position <= tray_position_next;
      phase_index   <= phase_index_next;
      step_period   <= step_period_next;
      tick_count    <= tick_count_next;
      step_index    <= step_index_next;
      step_total    <= step_total_next;
      reverse_dir   <= reverse_dir_next;
      busy          <= busy_next;
      drive_pattern <= drive_pattern_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      coil_pattern <= drive_pattern_next;
      moving       <= busy_next;
      move_done    <= done_next;
      rejected     <= rej_next;
    end
  end

endmodule

FILE: sv/stp_checker.sv
// Port-level checker for the stepper tray positioner, bound to the top level.
`include "assert_macros.svh"

module stp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [stp_pkg::PATTERN_W-1:0] coil_pattern,
  input logic                          moving,
  input logic                          move_done,
  input logic                          rejected
);

  // A stalled result keeps its payload
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(coil_pattern) && $stable(moving) && $stable(move_done) && $stable(rejected), "stalled result changed")

  // No transaction is taken while a result is stuck in the output register
  `ASSERT_IMPL(a_no_take_when_full, out_valid && !out_ready, !in_ready, "input taken while output full")

  // A finished move leaves the motor idle
  `ASSERT_IMPL(a_done_idle, out_valid && move_done, !moving && !rejected, "done while still moving")

  // A rejected command only happens during a move and does not end it
  `ASSERT_IMPL(a_reject_busy, out_valid && rejected, moving, "reject while idle")

  // The output register comes out of reset empty
  `ASSERT_IMPL(a_reset_empty, $past(rst), !out_valid, "result valid after reset")

endmodule

bind stepper_tray_positioner_core stp_checker u_stp_checker (.*);

FILE: bench/stepper_tray_positioner_core_tb.sv
// Self-checking testbench for the stepper tray positioner core: moves, ramps, ticks, registers.
`timescale 1ns / 1ps

module stepper_tray_positioner_core_tb;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int SETTLE_CYCLES = 8;
  // Index past the last register: the write is taken and dropped
  localparam logic [stp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hFF;

  typedef logic [stp_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct {
    logic           kind;
    stp_pkg::tray_t target;
  } tray_cmd_t;

  typedef struct {
    stp_pkg::pattern_t coil;
    logic              moving;
    logic              done;
    logic              rej;
  } tray_result_t;

  typedef struct {
    stp_pkg::period_t slow;
    stp_pkg::period_t fast;
    stp_pkg::steps_t  quarter;
    stp_pkg::steps_t  half;
  } tray_cfg_t;

  typedef struct {
    stp_pkg::tray_t    tray;
    stp_pkg::phase_t   phase;
    stp_pkg::period_t  period;
    stp_pkg::period_t  ticks;
    stp_pkg::steps_t   idx;
    stp_pkg::steps_t   total;
    logic              rev;
    logic              busy;
    stp_pkg::pattern_t drive;
  } tray_state_t;

  // DUT signals; the driven inputs are known from time zero
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            kind = stp_pkg::KIND_TICK;
  stp_pkg::tray_t                  target_tray = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  stp_pkg::pattern_t               coil_pattern;
  logic                            moving;
  logic                            move_done;
  logic                            rejected;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [stp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  cfg_data_t                       cfg_data = '0;

  stepper_tray_positioner_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .target_tray  (target_tray),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .coil_pattern (coil_pattern),
    .moving       (moving),
    .move_done    (move_done),
    .rejected     (rejected),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shared bench state
  tray_cmd_t    cmd_queue[$];
  tray_result_t expected_drive[$];
  tray_cfg_t    live_cfg;
  tray_state_t  chk_state;
  tray_state_t  gen_state;
  int           fail_count = 0;
  int           counted = 0;
  bit           in_took = 1'b0;
  bit           out_took = 1'b0;
  bit           hold_req = 1'b0;
  int           in_gap = 0;
  int           in_burst = 0;
  int           out_gap = 0;
  int           out_burst = 0;
  int           hold_left = 0;
  int           idle_cycles = 0;
  tray_cmd_t    drv_cmd;
  tray_cmd_t    acc_cmd;
  tray_result_t acc_res;
  tray_result_t want;

  // Hold time saturation to 1..31
  function automatic stp_pkg::period_t sat_period(input int p);
    if (p < int'(stp_pkg::PERIOD_MIN)) begin
      return stp_pkg::PERIOD_MIN;
    end
    if (p > int'(stp_pkg::PERIOD_MAX)) begin
      return stp_pkg::PERIOD_MAX;
    end
    return stp_pkg::period_t'(p);
  endfunction

  // Coil drive table, read backwards for reverse moves
  function automatic stp_pkg::pattern_t coil_for(input stp_pkg::phase_t ph, input logic rv);
    stp_pkg::phase_t   slot;
    stp_pkg::pattern_t pat;
    slot = rv ? (2'd3 - ph) : ph;
    case (slot)
      2'd0:    pat = 6'h35;
      2'd1:    pat = 6'h36;
      2'd2:    pat = 6'h2E;
      default: pat = 6'h2D;
    endcase
    return pat;
  endfunction

  function automatic void tray_reset(output tray_state_t s);
    s.tray   = '0;
    s.phase  = '0;
    s.period = stp_pkg::SLOW_PERIOD_RST;
    s.ticks  = '0;
    s.idx    = '0;
    s.total  = '0;
    s.rev    = 1'b0;
    s.busy   = 1'b0;
    s.drive  = stp_pkg::PATTERN_RST;
  endfunction

  // One transaction through the positioner: state update and the result it produces
  function automatic void tray_advance(inout tray_state_t s, input tray_cfg_t c,
                                       input tray_cmd_t cmd, output tray_result_t r);
    stp_pkg::tray_t  delta;
    stp_pkg::steps_t n;
    logic            rv;
    int              ramp;
    int              i;
    int              p;
    r.done = 1'b0;
    r.rej  = 1'b0;
    if (cmd.kind == stp_pkg::KIND_MOVE) begin
      if (s.busy) begin
        r.rej = 1'b1;
      end else begin
        delta = cmd.target - s.tray;
        n     = '0;
        rv    = 1'b0;
        case (delta)
          stp_pkg::DIST_FWD:  n = c.quarter;
          stp_pkg::DIST_REV: begin
            n  = c.quarter;
            rv = 1'b1;
          end
          stp_pkg::DIST_HALF: n = c.half;
          default:            n = '0;
        endcase
        s.tray = cmd.target;
        if (delta == stp_pkg::DIST_SAME || n == '0) begin
          r.done = 1'b1;
        end else begin
          s.rev    = rv;
          s.total  = n;
          s.idx    = '0;
          s.ticks  = '0;
          s.period = sat_period(int'(c.slow));
          s.busy   = 1'b1;
          s.drive  = coil_for(s.phase, s.rev);
          s.phase  = s.phase + 1'b1;
        end
      end
    end else if (s.busy) begin
      s.ticks = s.ticks + 1'b1;
      if (s.ticks >= s.period) begin
        // Ramp down at the start, back up over the tail
        ramp = int'(c.slow) - int'(c.fast);
        i    = int'(s.idx);
        p    = int'(s.period);
        if (i < ramp && p >= int'(c.fast)) begin
          p--;
        end
        if (int'(s.total) - i <= ramp && p <= int'(c.slow)) begin
          p++;
        end
        s.period = sat_period(p);
        s.ticks  = '0;
        s.idx    = s.idx + 1'b1;
        if (s.idx >= s.total) begin
          s.busy = 1'b0;
          r.done = 1'b1;
        end else begin
          s.drive = coil_for(s.phase, s.rev);
          s.phase = s.phase + 1'b1;
        end
      end
    end
    r.coil   = s.drive;
    r.moving = s.busy;
  endfunction

  function automatic tray_cmd_t mk_cmd(input logic k, input stp_pkg::tray_t t);
    tray_cmd_t c;
    c.kind   = k;
    c.target = t;
    return c;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones, occasional gap-free stretches
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Input driver: holds each transaction until taken, then idles or offers the next
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        drv_cmd = cmd_queue.pop_front();
        kind        <= drv_cmd.kind;
        target_tray <= drv_cmd.target;
        in_valid    <= 1'b1;
        in_gap = pick_gap(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        out_took = 1'b0;
        out_gap  = pick_gap(out_burst);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check each result transaction, then predict for each accepted input
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        if (expected_drive.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          want = expected_drive.pop_front();
          if (coil_pattern !== want.coil) begin
            $error("coil_pattern: expected %h, got %h", want.coil, coil_pattern);
            fail_count++;
          end
          if (moving !== want.moving) begin
            $error("moving: expected %b, got %b", want.moving, moving);
            fail_count++;
          end
          if (move_done !== want.done) begin
            $error("move_done: expected %b, got %b", want.done, move_done);
            fail_count++;
          end
          if (rejected !== want.rej) begin
            $error("rejected: expected %b, got %b", want.rej, rejected);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        acc_cmd = mk_cmd(kind, target_tray);
        tray_advance(chk_state, live_cfg, acc_cmd, acc_res);
        expected_drive.push_back(acc_res);
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("** stepper_tray_positioner_core: FAILED **");
        $finish;
      end
    end
  end

  // Queue one transaction, keeping a look-ahead copy of the state to shape sequences
  task automatic queue_item(input logic k, input stp_pkg::tray_t t);
    tray_cmd_t    c;
    tray_result_t r;
    c = mk_cmd(k, t);
    if (!(k == stp_pkg::KIND_TICK && !gen_state.busy)) begin
      counted++;
    end
    tray_advance(gen_state, live_cfg, c, r);
    cmd_queue.push_back(c);
  endtask

  // A move followed by ticks until it completes, with stray moves mixed in
  task automatic queue_move_sequence(input stp_pkg::tray_t t, input int rej_pct);
    queue_item(stp_pkg::KIND_MOVE, t);
    while (gen_state.busy) begin
      if ($urandom_range(0, 99) < rej_pct) begin
        queue_item(stp_pkg::KIND_MOVE, stp_pkg::tray_t'($urandom_range(0, 3)));
      end
      queue_item(stp_pkg::KIND_TICK, '0);
    end
  endtask

  // Pause the sender until every expected result has come back
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (cmd_queue.size() != 0 || in_valid || expected_drive.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stp_pkg::CFG_INDEX_W-1:0] idx,
                           input cfg_data_t val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      stp_pkg::REG_SLOW_PERIOD:  live_cfg.slow    = val[stp_pkg::PERIOD_W-1:0];
      stp_pkg::REG_FAST_PERIOD:  live_cfg.fast    = val[stp_pkg::PERIOD_W-1:0];
      stp_pkg::REG_QUARTER_STEP: live_cfg.quarter = val;
      stp_pkg::REG_HALF_STEP:    live_cfg.half    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input int slow, input int fast, input int quarter, input int half);
    wait_drained();
    write_reg(stp_pkg::REG_SLOW_PERIOD, cfg_data_t'(slow));
    write_reg(stp_pkg::REG_FAST_PERIOD, cfg_data_t'(fast));
    write_reg(stp_pkg::REG_QUARTER_STEP, cfg_data_t'(quarter));
    write_reg(stp_pkg::REG_HALF_STEP, cfg_data_t'(half));
  endtask

  // Random mix: mostly complete moves, some cut short, some loose transactions
  task automatic queue_random(input int budget);
    int r;
    counted = 0;
    while (counted < budget) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        queue_move_sequence(stp_pkg::tray_t'($urandom_range(0, 3)), 4);
      end else if (r < 90) begin
        queue_item(stp_pkg::KIND_MOVE, stp_pkg::tray_t'($urandom_range(0, 3)));
        repeat ($urandom_range(0, 6)) queue_item(stp_pkg::KIND_TICK, '0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_item(logic'($urandom_range(0, 1)), stp_pkg::tray_t'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  // Stimulus sequencing
  initial begin
    live_cfg.slow    = stp_pkg::SLOW_PERIOD_RST;
    live_cfg.fast    = stp_pkg::FAST_PERIOD_RST;
    live_cfg.quarter = stp_pkg::QUARTER_STEP_RST;
    live_cfg.half    = stp_pkg::HALF_STEP_RST;
    tray_reset(chk_state);
    tray_reset(gen_state);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: full ramped quarter turn with the receiver held off at the start
    hold_req = 1'b1;
    queue_move_sequence(stp_pkg::DIST_FWD, 3);

    // Directed: idle tick, same tray, each direction, move while busy
    start_phase(2, 2, 1, 2);
    write_reg(REG_UNMAPPED, 8'hA5);
    queue_item(stp_pkg::KIND_TICK, '0);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray + stp_pkg::DIST_FWD);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray + stp_pkg::DIST_HALF);
    while (gen_state.busy) begin
      queue_item(stp_pkg::KIND_TICK, '0);
    end
    queue_move_sequence(gen_state.tray + stp_pkg::DIST_HALF, 0);
    queue_move_sequence(gen_state.tray + stp_pkg::DIST_REV, 0);

    // Step counts of zero: done at once, tray still updates
    start_phase(2, 2, 0, 0);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray + stp_pkg::DIST_FWD);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray + stp_pkg::DIST_REV);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray + stp_pkg::DIST_HALF);
    queue_item(stp_pkg::KIND_MOVE, gen_state.tray);

    // Extreme settings: long ramp, fast above slow, zero slow period, longest moves
    start_phase(30, 2, 3, 5);
    queue_random(100);
    start_phase(2, 30, 2, 3);
    queue_random(60);
    start_phase(0, 0, 4, 6);
    queue_random(60);
    start_phase(2, 2, 255, 255);
    queue_move_sequence(gen_state.tray + stp_pkg::DIST_HALF, 1);

    // Random settings, a move sometimes still running when the next registers land
    repeat (8) begin
      start_phase($urandom_range(2, 9), $urandom_range(2, 9),
                  ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10),
                  ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14));
      queue_random(50);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_drive.size() == 0) begin
      $display("** stepper_tray_positioner_core: PASSED **");
    end else begin
      $display("** stepper_tray_positioner_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/stp_pkg.sv
sv/stepper_tray_positioner_core.sv
sv/stp_checker.sv
bench/stepper_tray_positioner_core_tb.sv
